FILE: rtl/core/imu_sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame decoder package
// Frame layout constants, field widths and per-word scale factors.
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

	localparam int WORDS_PER_FRAME = 10;
	localparam int STORED_WORDS    = WORDS_PER_FRAME - 1;
	localparam int WORD_IDX_W      = $clog2(WORDS_PER_FRAME);
	localparam int BYTE_IDX_W      = 5;

	localparam logic [7:0]            SYNC_RESET = 8'hFF;
	localparam logic [16:0]           OFFSET_MID = 17'd32767;
	localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(WORDS_PER_FRAME - 1);

	// Result field widths
	localparam int ACCEL_W = 14;
	localparam int RATE_W  = 18;
	localparam int ROLL_W  = 17;
	localparam int PITCH_W = 16;
	localparam int YAW_W   = 17;
	localparam int TEMP_W  = 16;
	localparam int SCALED_W = 18;

	localparam int RESULT_W   = 8 + 3 * ACCEL_W + 3 * RATE_W + ROLL_W + PITCH_W + YAW_W + TEMP_W;
	localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_ID   = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	// Full-scale factor of each word in the frame
	function automatic logic [8:0] scale_of(input logic [WORD_IDX_W-1:0] w);
		logic [8:0] s;
		case (w)
			4'd0, 4'd1, 4'd2: s = 9'd20;
			4'd3, 4'd4, 4'd5: s = 9'd500;
			4'd6, 4'd8:       s = 9'd180;
			4'd7:             s = 9'd90;
			default:          s = 9'd100;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/imu_serial_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame decoder
// Byte stream in, one scaled sensor record out per complete frame.
// ----------------------------------------------------------------------------
// Feed received serial bytes on the slave stream, one transaction per byte.
// The block hunts for the sync marker (cfg register, reset 0xFF), takes the
// next byte as the sensor index, then collects ten big-endian 16-bit words.
// Each word is offset binary and is scaled to trunc((raw-32767)*S*256/32767),
// with S = 20 (accel x/y/z), 500 (rate roll/pitch/yaw), 180/90/180
// (angle roll/pitch/yaw) and 100 (temperature). One record appears on the
// master stream after the last data byte has been taken. It takes one byte
// per clock cycle unless held off; a record then passes the two-stage scaling
// pipe (a 16x9 multiply, then a reciprocal fold that divides by 32767) and the
// output register. Input is held off only while a finished record waits in
// the output register and the next record is ready to replace it.
// Write the marker only while the block is idle; a write mid-frame takes
// effect at the next hunt.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top
	import imu_sfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_wr_en,
	input  wire logic [7:0]           cfg_wr_data,
	// byte stream in
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [7:0] rx_byte
	// record stream out
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [7:0] sensor_id, [21:8] accel_x, [35:22] accel_y, [49:36] accel_z,
	// [67:50] rate_roll, [85:68] rate_pitch, [103:86] rate_yaw,
	// [120:104] angle_roll, [136:121] angle_pitch, [153:137] angle_yaw,
	// [169:154] temperature, upper bits zero
	output logic [M_TDATA_W-1:0]      m_tdata
);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [7:0]            sync_marker_q;
	phase_t                phase_q, phase_d;
	logic [BYTE_IDX_W-1:0] byte_index_q, byte_index_d;
	logic [7:0]            held_high_q, held_high_d;
	logic [7:0]            held_sensor_q, held_sensor_d;

	// stage 1: assembled word
	logic                  valid_s1;
	logic [15:0]           raw_s1;
	logic [WORD_IDX_W-1:0] word_s1;
	logic                  last_s1;
	logic [7:0]            sensor_s1;

	// stage 2: scaled magnitude before division
	logic                  valid_s2;
	logic [23:0]           prod_s2;
	logic                  neg_s2;
	logic [WORD_IDX_W-1:0] word_s2;
	logic                  last_s2;
	logic [7:0]            sensor_s2;

	// finished words of the current frame
	logic signed [SCALED_W-1:0] scaled_words_q [STORED_WORDS];

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	logic accept;
	logic stall;
	logic push;

	// Hold the pipe when a record is ready but the previous one is not taken
	assign stall    = valid_s2 && last_s2 && m_tvalid_q && !m_tready;
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_marker_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_marker_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Frame parser: next state
	// ------------------------------------------------------------------
	always_comb begin
		phase_d       = phase_q;
		byte_index_d  = byte_index_q;
		held_high_d   = held_high_q;
		held_sensor_d = held_sensor_q;
		if (accept) begin
			unique case (phase_q)
				PH_ID: begin
					held_sensor_d = s_tdata;
					byte_index_d  = '0;
					phase_d       = PH_DATA;
				end
				PH_DATA: begin
					if (!byte_index_q[0]) begin
						held_high_d  = s_tdata;
						byte_index_d = byte_index_q + 1'b1;
					end else if (byte_index_q[BYTE_IDX_W-1:1] == LAST_WORD) begin
						// last data byte: back to hunting
						phase_d      = PH_HUNT;
						byte_index_d = '0;
					end else begin
						byte_index_d = byte_index_q + 1'b1;
					end
				end
				default: begin
					// hunting, and the unused code
					phase_d = (s_tdata == sync_marker_q) ? PH_ID : PH_HUNT;
				end
			endcase
		end
	end

	// Frame parser: outputs (a word is complete on its low byte)
	always_comb begin
		push = 1'b0;
		unique case (phase_q)
			PH_DATA: push = accept && byte_index_q[0];
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			byte_index_q  <= '0;
			held_high_q   <= '0;
			held_sensor_q <= '0;
		end else begin
			phase_q       <= phase_d;
			byte_index_q  <= byte_index_d;
			held_high_q   <= held_high_d;
			held_sensor_q <= held_sensor_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: assembled raw word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			raw_s1    <= {held_high_q, s_tdata};
			word_s1   <= byte_index_q[BYTE_IDX_W-1:1];
			last_s1   <= (byte_index_q[BYTE_IDX_W-1:1] == LAST_WORD);
			sensor_s1 <= held_sensor_q;
		end
	end

	// Remove the offset, take the magnitude and multiply by the scale
	logic signed [16:0] diff_s1;
	logic [15:0]        mag_s1;
	logic [23:0]        prod_s1;

	always_comb begin
		diff_s1 = $signed({1'b0, raw_s1}) - $signed(OFFSET_MID);
		mag_s1  = diff_s1[16] ? 16'(-diff_s1) : diff_s1[15:0];
		prod_s1 = {8'd0, mag_s1} * {15'd0, scale_of(word_s1)};
	end

	// ------------------------------------------------------------------
	// Stage 2: divide by 32767 and restore the sign
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !stall) begin
			prod_s2   <= prod_s1;
			neg_s2    <= diff_s1[16];
			word_s2   <= word_s1;
			last_s2   <= last_s1;
			sensor_s2 <= sensor_s1;
		end
	end

	// 32767 = 2^15 - 1: fold the high part back onto the low part twice,
	// then one compare finishes the quotient.
	logic [31:0]                num_s2;
	logic [16:0]                q0_s2;
	logic [17:0]                fold1_s2;
	logic [2:0]                 q1_s2;
	logic [15:0]                fold2_s2;
	logic [16:0]                quot_s2;
	logic signed [SCALED_W-1:0] scaled_s2;

	always_comb begin
		num_s2    = {prod_s2, 8'd0};
		q0_s2     = num_s2[31:15];
		fold1_s2  = {1'b0, q0_s2} + {3'd0, num_s2[14:0]};
		q1_s2     = fold1_s2[17:15];
		fold2_s2  = {1'b0, fold1_s2[14:0]} + {13'd0, q1_s2};
		quot_s2   = q0_s2 + {14'd0, q1_s2}
		            + {16'd0, (fold2_s2 >= {1'b0, OFFSET_MID[14:0]})};
		scaled_s2 = neg_s2 ? -$signed({1'b0, quot_s2}) : $signed({1'b0, quot_s2});
	end

	// Hold finished words until the frame completes
	always_ff @(posedge clk) begin
		if (valid_s2 && !last_s2) begin
			scaled_words_q[word_s2] <= scaled_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic load_out;
	assign load_out = valid_s2 && last_s2 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {
				(M_TDATA_W - RESULT_W)'(0),
				scaled_s2[TEMP_W-1:0],
				scaled_words_q[8][YAW_W-1:0],
				scaled_words_q[7][PITCH_W-1:0],
				scaled_words_q[6][ROLL_W-1:0],
				scaled_words_q[5][RATE_W-1:0],
				scaled_words_q[4][RATE_W-1:0],
				scaled_words_q[3][RATE_W-1:0],
				scaled_words_q[2][ACCEL_W-1:0],
				scaled_words_q[1][ACCEL_W-1:0],
				scaled_words_q[0][ACCEL_W-1:0],
				sensor_s2
			};
		end
	end

endmodule
`default_nettype wire
